// ----- hdl/pvst_pkg.sv -----
// Package for the polygon vertex screen transform.
// Shared widths, register indexes, job record and the constant vertex table.
// No dependencies.
`timescale 1ns / 1ps
package pvst_pkg;

  localparam int MAX_SIDES_DEF  = 32;
  localparam int COORD_BITS_DEF = 16;

  localparam int ENT_W  = 16;   // Q4.11 matrix entry
  localparam int VTX_W  = 16;   // Q1.14 table coordinate
  localparam int PROD_W = 32;
  localparam int SUM_W  = 32;
  localparam int SIZE_W = 13;
  localparam int NUM_W  = SUM_W + SIZE_W + 1;
  localparam int DEN_W  = 32;
  localparam int CNT_W  = 6;
  localparam int IDX_W  = 5;
  localparam int TBL_W  = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;

  localparam int FIFO_DEPTH = 4;  // power of two
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_ROW0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd5;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 13'd800;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 13'd600;

  typedef struct packed {
    logic [CFG_DAT_W-1:0] row0;
    logic [CFG_DAT_W-1:0] row1;
    logic [CFG_DAT_W-1:0] row3;
    logic [SIZE_W-1:0]    width;
    logic [SIZE_W-1:0]    height;
  } cfg_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] num_x;
    logic signed [NUM_W-1:0] num_y;
    logic signed [DEN_W-1:0] den;
    logic                    w_zero;
    logic [IDX_W-1:0]        idx;
    logic                    last;
  } vtx_job_t;

  function automatic logic [TBL_W-1:0] shape_base(input logic [1:0] s);
    logic [TBL_W-1:0] b;
    unique case (s)
      2'd0: b = 6'd0;
      2'd1: b = 6'd3;
      2'd2: b = 6'd7;
      default: b = 6'd12;
    endcase
    return b;
  endfunction

  function automatic logic [CNT_W-1:0] shape_count(input logic [1:0] s);
    logic [CNT_W-1:0] n;
    unique case (s)
      2'd0: n = 6'd3;
      2'd1: n = 6'd4;
      2'd2: n = 6'd5;
      default: n = 6'd32;
    endcase
    return n;
  endfunction

  function automatic logic [2*VTX_W-1:0] pk(input int x, input int y);
    return {x[VTX_W-1:0], y[VTX_W-1:0]};
  endfunction

  // {x, y} in Q1.14
  function automatic logic [2*VTX_W-1:0] vertex_lut(input logic [TBL_W-1:0] i);
    logic [2*VTX_W-1:0] v;
    unique case (i)
      6'd0:  v = pk(0, 8192);
      6'd1:  v = pk(-7094, -4096);
      6'd2:  v = pk(7094, -4096);
      6'd3:  v = pk(8192, 8192);
      6'd4:  v = pk(-8192, 8192);
      6'd5:  v = pk(-8192, -8192);
      6'd6:  v = pk(8192, -8192);
      6'd7:  v = pk(0, 8192);
      6'd8:  v = pk(-7791, 2531);
      6'd9:  v = pk(-4815, -6627);
      6'd10: v = pk(4815, -6627);
      6'd11: v = pk(7791, 2531);
      6'd12: v = pk(0, 8192);
      6'd13: v = pk(-1598, 8035);
      6'd14: v = pk(-3135, 7568);
      6'd15: v = pk(-4551, 6811);
      6'd16: v = pk(-5793, 5793);
      6'd17: v = pk(-6811, 4551);
      6'd18: v = pk(-7568, 3135);
      6'd19: v = pk(-8035, 1598);
      6'd20: v = pk(-8192, 0);
      6'd21: v = pk(-8035, -1598);
      6'd22: v = pk(-7568, -3135);
      6'd23: v = pk(-6811, -4551);
      6'd24: v = pk(-5793, -5793);
      6'd25: v = pk(-4551, -6811);
      6'd26: v = pk(-3135, -7568);
      6'd27: v = pk(-1598, -8035);
      6'd28: v = pk(0, -8192);
      6'd29: v = pk(1598, -8035);
      6'd30: v = pk(3135, -7568);
      6'd31: v = pk(4551, -6811);
      6'd32: v = pk(5793, -5793);
      6'd33: v = pk(6811, -4551);
      6'd34: v = pk(7568, -3135);
      6'd35: v = pk(8035, -1598);
      6'd36: v = pk(8192, 0);
      6'd37: v = pk(8035, 1598);
      6'd38: v = pk(7568, 3135);
      6'd39: v = pk(6811, 4551);
      6'd40: v = pk(5793, 5793);
      6'd41: v = pk(4551, 6811);
      6'd42: v = pk(3135, 7568);
      6'd43: v = pk(1598, 8035);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/polygon_vertex_screen_transform.sv -----
// Top level of the polygon vertex screen transform: config registers and wiring.
// Depends on pvst_pkg, pvst_front, pvst_fifo, pvst_back.
`timescale 1ns / 1ps
// A shape code is taken on start while busy is low; busy then stays high until
// the last vertex result has been strobed. Each vertex gives one result on
// result_valid_o for a single cycle, in vertex order, with last_vertex_o on the
// final one; results cannot be held off. The matrix pipeline issues a vertex per
// cycle while the job queue has room for every job in flight, but each vertex
// then passes through the pair of bit-serial dividers, which take a new vertex
// only once done with the last one. Configuration is accepted on any cycle
// and must only be written while busy is low.
module polygon_vertex_screen_transform import pvst_pkg::*; #(
  parameter int MAX_SIDES  = MAX_SIDES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   shape_code_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DAT_W-1:0]         cfg_data_i,
  output logic                         result_valid_o,
  output logic signed [COORD_BITS-1:0] screen_x_o,
  output logic signed [COORD_BITS-1:0] screen_y_o,
  output logic [IDX_W-1:0]             vertex_number_o,
  output logic                         last_vertex_o,
  output logic                         saturated_o
);

  cfg_t               cfg_q;
  logic               accept, fe_busy, be_busy, push, pop, empty;
  vtx_job_t           job_in, job_out;
  logic [FIFO_CW-1:0] fifo_cnt;

  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row0   <= '0;
      cfg_q.row1   <= '0;
      cfg_q.row3   <= '0;
      cfg_q.width  <= WIDTH_RST;
      cfg_q.height <= HEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_ROW0:   cfg_q.row0   <= cfg_data_i;
        REG_ROW1:   cfg_q.row1   <= cfg_data_i;
        REG_ROW2:   ;  // z is always zero, row 2 has no effect
        REG_ROW3:   cfg_q.row3   <= cfg_data_i;
        REG_WIDTH:  cfg_q.width  <= cfg_data_i[SIZE_W-1:0];
        REG_HEIGHT: cfg_q.height <= cfg_data_i[SIZE_W-1:0];
        default:    ;
      endcase
    end
  end

  pvst_front #(.MAX_SIDES(MAX_SIDES)) u_front (
    .clk_i, .rst_ni, .accept_i(accept), .shape_code_i, .cfg_i(cfg_q),
    .fifo_cnt_i(fifo_cnt), .push_o(push), .job_o(job_in), .busy_o(fe_busy)
  );

  pvst_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(job_in), .pop_i(pop),
    .data_o(job_out), .empty_o(empty), .count_o(fifo_cnt)
  );

  pvst_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .job_i(job_out), .pop_o(pop),
    .busy_o(be_busy), .valid_o(result_valid_o), .screen_x_o, .screen_y_o,
    .vertex_number_o, .last_vertex_o, .saturated_o
  );

  assign busy = fe_busy | !empty | be_busy;

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("busy not raised after start transfer");

  a_result_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("back-to-back result strobes");

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt <= FIFO_CW'(FIFO_DEPTH)) else $error("job queue overflow");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> fifo_cnt < FIFO_CW'(FIFO_DEPTH)) else $error("push into full queue");

endmodule

// ----- hdl/pvst_front.sv -----
// Front end: walks the vertices of a shape and runs the matrix product pipeline.
// Produces one divide job per vertex for the queue. Depends on pvst_pkg.
`timescale 1ns / 1ps
module pvst_front import pvst_pkg::*; #(
  parameter int MAX_SIDES = MAX_SIDES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [1:0]           shape_code_i,
  input  cfg_t                 cfg_i,
  input  logic [FIFO_CW-1:0]   fifo_cnt_i,
  output logic                 push_o,
  output vtx_job_t             job_o,
  output logic                 busy_o
);

  localparam int CAP = (MAX_SIDES < 32) ? MAX_SIDES : 32;
  localparam logic [CNT_W-1:0] CAP_N = CNT_W'(CAP);
  localparam int STAGES = 5;

  logic             act_q;
  logic [1:0]       shape_q;
  logic [IDX_W-1:0] k_q;
  logic [CNT_W-1:0] n_q, n_d;
  logic [STAGES:1]  v_q;
  logic [3:0]       inflight, room;
  logic             issue, last0;

  always_comb begin
    n_d = shape_count(shape_code_i);
    if (n_d > CAP_N) n_d = CAP_N;
  end

  always_comb begin
    inflight = '0;
    for (int i = 1; i <= STAGES; i++) inflight = inflight + 4'(v_q[i]);
  end

  // keep every job already in flight guaranteed a queue slot
  assign room  = 4'(fifo_cnt_i) + inflight;
  assign issue = act_q && (room < 4'(FIFO_DEPTH));
  assign last0 = ({1'b0, k_q} + 6'd1) == n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= 1'b0;
      shape_q <= '0;
      k_q     <= '0;
      n_q     <= '0;
      v_q     <= '0;
    end else begin
      v_q <= {v_q[STAGES-1:1], issue};
      if (accept_i) begin
        act_q   <= 1'b1;
        shape_q <= shape_code_i;
        k_q     <= '0;
        n_q     <= n_d;
      end else if (issue) begin
        k_q <= k_q + 5'd1;
        if (last0) act_q <= 1'b0;
      end
    end
  end

  // matrix entries used: z is always zero so row 2 drops out
  logic signed [ENT_W-1:0] m00, m01, m03, m10, m11, m13, m30, m31, m33;
  assign m00 = cfg_i.row0[15:0];
  assign m01 = cfg_i.row0[31:16];
  assign m03 = cfg_i.row0[63:48];
  assign m10 = cfg_i.row1[15:0];
  assign m11 = cfg_i.row1[31:16];
  assign m13 = cfg_i.row1[63:48];
  assign m30 = cfg_i.row3[15:0];
  assign m31 = cfg_i.row3[31:16];
  assign m33 = cfg_i.row3[63:48];

  logic [2*VTX_W-1:0]       lut;
  logic signed [VTX_W-1:0]  vx1_q, vy1_q;
  logic [IDX_W-1:0]         idx_q [2:STAGES];
  logic [IDX_W-1:0]         idx1_q;
  logic                     last1_q;
  logic [STAGES:2]          last_q;
  logic signed [PROD_W-1:0] pxa_q, pxb_q, pya_q, pyb_q, pwa_q, pwb_q;
  logic signed [SUM_W-1:0]  x_q, y_q, w_q;
  logic signed [SUM_W-1:0]  a_q, b_q, den_q;
  logic                     wz_q;
  logic signed [NUM_W-1:0]  nx_q, ny_q;
  logic signed [DEN_W-1:0]  den5_q;
  logic                     wz5_q;

  assign lut = vertex_lut(shape_base(shape_q) + TBL_W'(k_q));

  always_ff @(posedge clk_i) begin
    vx1_q   <= lut[2*VTX_W-1:VTX_W];
    vy1_q   <= lut[VTX_W-1:0];
    idx1_q  <= k_q;
    last1_q <= last0;

    pxa_q <= vx1_q * m00;
    pxb_q <= vy1_q * m10;
    pya_q <= vx1_q * m01;
    pyb_q <= vy1_q * m11;
    pwa_q <= vx1_q * m03;
    pwb_q <= vy1_q * m13;
    idx_q[2]  <= idx1_q;
    last_q[2] <= last1_q;

    x_q <= pxa_q + pxb_q + {{2{m30[ENT_W-1]}}, m30, 14'b0};
    y_q <= pya_q + pyb_q + {{2{m31[ENT_W-1]}}, m31, 14'b0};
    w_q <= pwa_q + pwb_q + {{2{m33[ENT_W-1]}}, m33, 14'b0};
    idx_q[3]  <= idx_q[2];
    last_q[3] <= last_q[2];

    a_q   <= x_q + w_q;
    b_q   <= w_q - y_q;
    den_q <= w_q <<< 1;
    wz_q  <= (w_q == '0);
    idx_q[4]  <= idx_q[3];
    last_q[4] <= last_q[3];

    nx_q   <= a_q * $signed({1'b0, cfg_i.width});
    ny_q   <= b_q * $signed({1'b0, cfg_i.height});
    den5_q <= den_q;
    wz5_q  <= wz_q;
    idx_q[5]  <= idx_q[4];
    last_q[5] <= last_q[4];
  end

  assign push_o       = v_q[STAGES];
  assign job_o.num_x  = nx_q;
  assign job_o.num_y  = ny_q;
  assign job_o.den    = den5_q;
  assign job_o.w_zero = wz5_q;
  assign job_o.idx    = idx_q[STAGES];
  assign job_o.last   = last_q[STAGES];
  assign busy_o       = act_q | (|v_q);

endmodule

// ----- hdl/pvst_fifo.sv -----
// Short job queue between the front end and the divide back end.
// Depends on pvst_pkg (job record, depth).
`timescale 1ns / 1ps
module pvst_fifo import pvst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  vtx_job_t           data_i,
  input  logic               pop_i,
  output vtx_job_t           data_o,
  output logic               empty_o,
  output logic [FIFO_CW-1:0] count_o
);

  vtx_job_t             mem_q [FIFO_DEPTH];
  logic [FIFO_PW-1:0]   wr_q, rd_q;
  logic [FIFO_CW-1:0]   cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + FIFO_CW'(push_i) - FIFO_CW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign data_o  = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

// ----- hdl/pvst_div.sv -----
// Bit-serial signed divider, one quotient bit per cycle, truncating toward zero.
// Clamps the quotient to COORD_BITS signed. Depends on pvst_pkg.
`timescale 1ns / 1ps
module pvst_div import pvst_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic signed [DEN_W-1:0] den_i,
  output logic                    done_o,
  output logic [COORD_BITS-1:0]   q_o,
  output logic                    sat_o
);

  localparam int C  = COORD_BITS;
  localparam int RW = (NUM_W > DEN_W + C) ? NUM_W : DEN_W + C;
  localparam int CW = $clog2(C + 1);
  localparam logic [C-1:0] Q_MAX = {1'b0, {(C-1){1'b1}}};
  localparam logic [C-1:0] Q_MIN = {1'b1, {(C-1){1'b0}}};

  logic [NUM_W-1:0] nmag;
  logic [DEN_W-1:0] dmag;
  logic [RW-1:0]    rem_q, dsh_q;
  logic [C-1:0]     qm_q;
  logic [CW-1:0]    cnt_q;
  logic             neg_q, ovf_q, done_q, ge;

  assign nmag = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
  assign dmag = den_i[DEN_W-1] ? DEN_W'(-den_i) : DEN_W'(den_i);
  assign ge   = rem_q >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(C);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 1'b1;
        done_q <= (cnt_q == CW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= RW'(nmag);
      dsh_q <= RW'(dmag) << (C - 1);
      qm_q  <= '0;
      neg_q <= num_i[NUM_W-1] ^ den_i[DEN_W-1];
      // quotient magnitude would need more than C bits
      ovf_q <= RW'(nmag) >= (RW'(dmag) << C);
    end else if (cnt_q != '0) begin
      if (ge) rem_q <= rem_q - dsh_q;
      qm_q  <= {qm_q[C-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  always_comb begin
    sat_o = ovf_q || (!neg_q && qm_q[C-1]) || (neg_q && (qm_q > Q_MIN));
    if (sat_o)      q_o = neg_q ? Q_MIN : Q_MAX;
    else if (neg_q) q_o = C'(-qm_q);
    else            q_o = qm_q;
  end

  assign done_o = done_q;

endmodule

// ----- hdl/pvst_back.sv -----
// Back end: pops jobs, runs the x and y divides in parallel, registers results.
// Depends on pvst_pkg and pvst_div.
`timescale 1ns / 1ps
module pvst_back import pvst_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         empty_i,
  input  vtx_job_t                     job_i,
  output logic                         pop_o,
  output logic                         busy_o,
  output logic                         valid_o,
  output logic signed [COORD_BITS-1:0] screen_x_o,
  output logic signed [COORD_BITS-1:0] screen_y_o,
  output logic [IDX_W-1:0]             vertex_number_o,
  output logic                         last_vertex_o,
  output logic                         saturated_o
);

  typedef enum logic {S_IDLE, S_RUN} state_e;

  state_e                 state_q;
  logic                   done_x, done_y, sat_x, sat_y;
  logic [COORD_BITS-1:0]  q_x, q_y;
  logic                   wz_q, last_q;
  logic [IDX_W-1:0]       idx_q;
  logic                   valid_q, lastv_q, sat_q;
  logic [COORD_BITS-1:0]  x_q, y_q;
  logic [IDX_W-1:0]       num_q;

  assign pop_o = (state_q == S_IDLE) && !empty_i;

  pvst_div #(.COORD_BITS(COORD_BITS)) u_div_x (
    .clk_i, .rst_ni, .start_i(pop_o), .num_i(job_i.num_x), .den_i(job_i.den),
    .done_o(done_x), .q_o(q_x), .sat_o(sat_x)
  );

  pvst_div #(.COORD_BITS(COORD_BITS)) u_div_y (
    .clk_i, .rst_ni, .start_i(pop_o), .num_i(job_i.num_y), .den_i(job_i.den),
    .done_o(done_y), .q_o(q_y), .sat_o(sat_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
      wz_q    <= 1'b0;
      last_q  <= 1'b0;
      idx_q   <= '0;
      lastv_q <= 1'b0;
      sat_q   <= 1'b0;
      x_q     <= '0;
      y_q     <= '0;
      num_q   <= '0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            wz_q    <= job_i.w_zero;
            last_q  <= job_i.last;
            idx_q   <= job_i.idx;
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          if (done_x && done_y) begin
            valid_q <= 1'b1;
            x_q     <= wz_q ? '0 : q_x;
            y_q     <= wz_q ? '0 : q_y;
            sat_q   <= wz_q | sat_x | sat_y;
            num_q   <= idx_q;
            lastv_q <= last_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o          = (state_q == S_RUN);
  assign valid_o         = valid_q;
  assign screen_x_o      = x_q;
  assign screen_y_o      = y_q;
  assign vertex_number_o = num_q;
  assign last_vertex_o   = lastv_q;
  assign saturated_o     = sat_q;

endmodule
